FILE: design/adll_pkg.sv
// shared types and constants for the array doubly linked list block
// no dependencies; imported by every module of the block

package adll_pkg;

  // default table depth, handed down as the SLOTS parameter
  localparam int SLOTS_DEF = 16;

  // fixed field widths
  localparam int ACT_W  = 3;
  localparam int STAT_W = 3;
  localparam int PAY_W  = 64;

  // action codes carried on in_action
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD_FIRST = 3'd0,
    ACT_ADD_AFTER = 3'd1,
    ACT_ADD_LAST  = 3'd2,
    ACT_DEL_FIRST = 3'd3,
    ACT_DEL_AFTER = 3'd4,
    ACT_DEL_LAST  = 3'd5,
    ACT_CLEAR_ALL = 3'd6,
    ACT_READ_SLOT = 3'd7
  } action_t;

  // status codes carried on out_status
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FREE_POS = 3'd3,
    ST_NO_NEXT  = 3'd4
  } status_t;

endpackage

FILE: design/adll_free_enc.sv
// lowest free slot finder: priority encoder over the slot-in-use flags
// depends on adll_pkg

module adll_free_enc #(
  parameter int SLOTS = adll_pkg::SLOTS_DEF
) (
  input  logic [SLOTS-1:0]              in_use,
  output logic [$clog2(SLOTS+1)-1:0]    free_idx
);
  import adll_pkg::*;

  localparam int SW = $clog2(SLOTS + 1);

  // scan from the top so the lowest free slot wins; SLOTS means none free
  always_comb begin
    free_idx = SW'(SLOTS);
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_idx = SW'(i);
      end
    end
  end

endmodule

FILE: design/adll_core.sv
// list state (flags, links, payloads, head, tail, count) and the
// single-pass action logic; depends on adll_pkg and adll_free_enc

module adll_core #(
  parameter int SLOTS = adll_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              acc,
  input  logic [adll_pkg::ACT_W-1:0]        action,
  input  logic [$clog2(SLOTS)-1:0]          position,
  input  logic [adll_pkg::PAY_W-1:0]        payload,
  output logic [adll_pkg::STAT_W-1:0]       res_status,
  output logic [$clog2(SLOTS+1)-1:0]        res_slot,
  output logic [$clog2(SLOTS+1)-1:0]        res_count,
  output logic [$clog2(SLOTS+1)-1:0]        res_head,
  output logic [$clog2(SLOTS+1)-1:0]        res_tail,
  output logic [adll_pkg::PAY_W-1:0]        res_payload,
  output logic [$clog2(SLOTS+1)-1:0]        res_prev,
  output logic [$clog2(SLOTS+1)-1:0]        res_next
);
  import adll_pkg::*;

  localparam int SW = $clog2(SLOTS + 1);
  localparam int PW = $clog2(SLOTS);
  localparam logic [SW-1:0] NIL = SW'(SLOTS);

  // list state
  logic [SLOTS-1:0]  in_use_r, in_use_nxt;
  logic [SW-1:0]     next_r [SLOTS];
  logic [SW-1:0]     next_nxt [SLOTS];
  logic [SW-1:0]     prev_r [SLOTS];
  logic [SW-1:0]     prev_nxt [SLOTS];
  logic [PAY_W-1:0]  payload_r [SLOTS];
  logic [SW-1:0]     head_r, head_nxt;
  logic [SW-1:0]     tail_r, tail_nxt;
  logic [SW-1:0]     count_r, count_nxt;

  logic [SW-1:0]     free_idx;
  logic              pay_we;

  // lowest free slot
  adll_free_enc #(
    .SLOTS (SLOTS)
  ) u_free_enc (
    .in_use   (in_use_r),
    .free_idx (free_idx)
  );

  // action decode, link and unlink
  always_comb begin
    logic [SW-1:0] pos_ext;
    logic          pos_used;
    logic          do_link;
    logic          do_unlink;
    logic [SW-1:0] lp;
    logic [SW-1:0] ln;
    logic [SW-1:0] us;
    logic [SW-1:0] up;
    logic [SW-1:0] un;

    pos_ext  = SW'(position);
    pos_used = (pos_ext < NIL) && in_use_r[position];
    do_link   = 1'b0;
    do_unlink = 1'b0;
    lp = NIL;
    ln = NIL;
    us = NIL;
    up = NIL;
    un = NIL;

    in_use_nxt = in_use_r;
    next_nxt   = next_r;
    prev_nxt   = prev_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;

    res_status  = ST_OK;
    res_slot    = NIL;
    res_payload = '0;
    res_prev    = NIL;
    res_next    = NIL;

    case (action_t'(action))
      ACT_ADD_FIRST, ACT_ADD_LAST: begin
        if (free_idx == NIL) begin
          res_status = ST_FULL;
        end else begin
          do_link = 1'b1;
          lp = (action_t'(action) == ACT_ADD_FIRST) ? NIL : tail_r;
        end
      end
      ACT_ADD_AFTER: begin
        if (free_idx == NIL) begin
          res_status = ST_FULL;
        end else if (!pos_used) begin
          res_status = ST_FREE_POS;
        end else begin
          do_link = 1'b1;
          lp = pos_ext;
        end
      end
      ACT_DEL_FIRST, ACT_DEL_LAST: begin
        us = (action_t'(action) == ACT_DEL_FIRST) ? head_r : tail_r;
        if (us >= NIL) begin
          res_status = ST_EMPTY;
        end else begin
          do_unlink = 1'b1;
        end
      end
      ACT_DEL_AFTER: begin
        if (!pos_used) begin
          res_status = ST_FREE_POS;
        end else begin
          us = next_r[position];
          if (us >= NIL) begin
            res_status = ST_NO_NEXT;
          end else begin
            do_unlink = 1'b1;
          end
        end
      end
      ACT_CLEAR_ALL: begin
        in_use_nxt = '0;
        head_nxt   = NIL;
        tail_nxt   = NIL;
        count_nxt  = '0;
      end
      ACT_READ_SLOT: begin
        if (!pos_used) begin
          res_status = ST_FREE_POS;
        end else begin
          res_slot    = pos_ext;
          res_payload = payload_r[position];
          res_prev    = prev_r[position];
          res_next    = next_r[position];
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase

    // insert the free slot after lp (NIL puts it at the front)
    if (do_link) begin
      ln = (lp < NIL) ? next_r[lp[PW-1:0]] : head_r;
      in_use_nxt[free_idx[PW-1:0]] = 1'b1;
      prev_nxt[free_idx[PW-1:0]]   = lp;
      next_nxt[free_idx[PW-1:0]]   = ln;
      if (lp < NIL) begin
        next_nxt[lp[PW-1:0]] = free_idx;
      end else begin
        head_nxt = free_idx;
      end
      if (ln < NIL) begin
        prev_nxt[ln[PW-1:0]] = free_idx;
      end else begin
        tail_nxt = free_idx;
      end
      count_nxt = count_r + SW'(1);
      res_slot  = free_idx;
    end

    // take slot us out of the chain
    if (do_unlink) begin
      up = prev_r[us[PW-1:0]];
      un = next_r[us[PW-1:0]];
      if (up < NIL) begin
        next_nxt[up[PW-1:0]] = un;
      end else begin
        head_nxt = un;
      end
      if (un < NIL) begin
        prev_nxt[un[PW-1:0]] = up;
      end else begin
        tail_nxt = up;
      end
      in_use_nxt[us[PW-1:0]] = 1'b0;
      if (count_r != '0) begin
        count_nxt = count_r - SW'(1);
      end
      res_slot = us;
    end

    pay_we = do_link;

    res_count = count_nxt;
    res_head  = head_nxt;
    res_tail  = tail_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      head_r   <= NIL;
      tail_r   <= NIL;
      count_r  <= '0;
    end else if (acc) begin
      in_use_r <= in_use_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
    end
  end

  // links, no reset: only read once their slot is in use
  always_ff @(posedge clk) begin
    if (acc) begin
      next_r <= next_nxt;
      prev_r <= prev_nxt;
    end
  end

  // payload store, written at the new slot on an add
  always_ff @(posedge clk) begin
    if (acc && pay_we) begin
      payload_r[free_idx[PW-1:0]] <= payload;
    end
  end

endmodule

FILE: design/adll_out_buf.sv
// two-entry result buffer: output register plus skid entry, registered ready
// depends on adll_pkg

module adll_out_buf #(
  parameter int W = adll_pkg::PAY_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  import adll_pkg::*;

  logic         v0_r, v1_r;
  logic [W-1:0] d0_r, d1_r;
  logic         push, pop;

  assign push       = push_valid && !v1_r;
  assign pop        = v0_r && pop_ready;
  assign push_ready = !v1_r;
  assign pop_valid  = v0_r;
  assign pop_data   = d0_r;

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (push && !pop) begin
        if (v0_r) begin
          v1_r <= 1'b1;
        end else begin
          v0_r <= 1'b1;
        end
      end else if (pop && !push) begin
        if (v1_r) begin
          v1_r <= 1'b0;
        end else begin
          v0_r <= 1'b0;
        end
      end
    end
  end

  // beat data
  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (v0_r) begin
        d1_r <= push_data;
      end else begin
        d0_r <= push_data;
      end
    end else if (pop && !push) begin
      d0_r <= d1_r;
    end else if (push && pop) begin
      d0_r <= push_data;
    end
  end

endmodule

FILE: design/array_doubly_linked_list.sv
// Array-based doubly linked list over a table of SLOTS slots.
// Input channel (in_valid/in_ready): one beat carries an action, a
// position and a 64-bit payload. Adds take the lowest-numbered free slot;
// deletes unlink from the front, the back or after a position; clear_all
// empties the list; read_slot returns a slot's payload and links.
// Result channel (out_valid/out_ready): one beat per input beat, in order,
// with status, slot touched, entry count, head, tail and read fields.
// The result is registered in the output buffer. Throughput: one action
// per cycle while in_ready is high; the whole action is one pass of
// combinational logic from the state registers and the input beat,
// with the free-slot priority encoder and the link muxes as the path.
// Stall: a two-entry output buffer holds results; in_ready drops only
// when both entries are full, so one more beat is taken while a result
// waits. Reset (rst_n low, synchronous) frees every slot, empties the
// list and drops both buffer entries; no clearing pass is needed.
// Depends on adll_pkg, adll_core, adll_free_enc and adll_out_buf.

module array_doubly_linked_list #(
  parameter int SLOTS = adll_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [adll_pkg::ACT_W-1:0]        in_action,
  input  logic [$clog2(SLOTS)-1:0]          in_position,
  input  logic [adll_pkg::PAY_W-1:0]        in_payload,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [adll_pkg::STAT_W-1:0]       out_status,
  output logic [$clog2(SLOTS+1)-1:0]        out_slot,
  output logic [$clog2(SLOTS+1)-1:0]        out_entry_count,
  output logic [$clog2(SLOTS+1)-1:0]        out_head_slot,
  output logic [$clog2(SLOTS+1)-1:0]        out_tail_slot,
  output logic [adll_pkg::PAY_W-1:0]        out_read_payload,
  output logic [$clog2(SLOTS+1)-1:0]        out_read_prev,
  output logic [$clog2(SLOTS+1)-1:0]        out_read_next
);
  import adll_pkg::*;

  localparam int SW    = $clog2(SLOTS + 1);
  localparam int RES_W = STAT_W + PAY_W + 6 * SW;

  logic              acc;
  logic [STAT_W-1:0] res_status;
  logic [SW-1:0]     res_slot, res_count, res_head, res_tail;
  logic [SW-1:0]     res_prev, res_next;
  logic [PAY_W-1:0]  res_payload;
  logic [RES_W-1:0]  res_bits, out_bits;

  assign acc = in_valid && in_ready;

  // list state and action logic
  adll_core #(
    .SLOTS (SLOTS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .action      (in_action),
    .position    (in_position),
    .payload     (in_payload),
    .res_status  (res_status),
    .res_slot    (res_slot),
    .res_count   (res_count),
    .res_head    (res_head),
    .res_tail    (res_tail),
    .res_payload (res_payload),
    .res_prev    (res_prev),
    .res_next    (res_next)
  );

  // pack the result beat
  assign res_bits = {res_status, res_slot, res_count, res_head, res_tail,
                     res_payload, res_prev, res_next};

  // result register with skid entry
  adll_out_buf #(
    .W (RES_W)
  ) u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (res_bits),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_bits)
  );

  // unpack onto the result ports
  assign {out_status, out_slot, out_entry_count, out_head_slot, out_tail_slot,
          out_read_payload, out_read_prev, out_read_next} = out_bits;

endmodule

FILE: bench/array_doubly_linked_list_tb.sv
// self-checking bench for the array doubly linked list block
// drives action beats, predicts every result beat and compares it field by field
// depends on adll_pkg and the array_doubly_linked_list top level
`timescale 1ns / 100ps

module array_doubly_linked_list_tb;
  import adll_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int POS_W = $clog2(NSLOT);
  localparam int IDX_W = $clog2(NSLOT + 1);
  localparam logic [IDX_W-1:0] NO_SLOT = IDX_W'(NSLOT);
  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_ITEMS = 150;
  localparam int HOLD_AT_BEAT = 400;
  localparam int HOLD_CYCLES = 96;
  localparam int LIMIT = 200000;

  typedef struct {
    action_t            act;
    logic [POS_W-1:0]   pos;
    logic [PAY_W-1:0]   data;
  } list_action_t;

  typedef struct {
    status_t            status;
    logic [IDX_W-1:0]   slot;
    logic [IDX_W-1:0]   count;
    logic [IDX_W-1:0]   head;
    logic [IDX_W-1:0]   tail;
    logic [PAY_W-1:0]   payload;
    logic [IDX_W-1:0]   prv;
    logic [IDX_W-1:0]   nxt;
  } list_reply_t;

  // dut ports; every driven input is known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ACT_W-1:0] in_action = '0;
  logic [POS_W-1:0] in_position = '0;
  logic [PAY_W-1:0] in_payload = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [IDX_W-1:0] out_slot;
  logic [IDX_W-1:0] out_entry_count;
  logic [IDX_W-1:0] out_head_slot;
  logic [IDX_W-1:0] out_tail_slot;
  logic [PAY_W-1:0] out_read_payload;
  logic [IDX_W-1:0] out_read_prev;
  logic [IDX_W-1:0] out_read_next;

  // shadow copy of the slot table
  bit               slot_used [NSLOT];
  logic [IDX_W-1:0] link_nxt [NSLOT];
  logic [IDX_W-1:0] link_prv [NSLOT];
  logic [PAY_W-1:0] slot_data [NSLOT];
  logic [IDX_W-1:0] list_head = NO_SLOT;
  logic [IDX_W-1:0] list_tail = NO_SLOT;
  logic [IDX_W-1:0] list_count = '0;

  list_action_t pending_q [$];
  list_reply_t  reply_q [$];

  int total_items = 0;
  int in_beats = 0;
  int out_beats = 0;
  int n_fail = 0;
  int cyc = 0;
  int status_seen [5];
  bit in_taken = 1'b0;
  bit held_off = 1'b0;
  int send_gap = 0;
  int ready_gap = 0;

  array_doubly_linked_list #(.SLOTS(NSLOT)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_position      (in_position),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_entry_count  (out_entry_count),
    .out_head_slot    (out_head_slot),
    .out_tail_slot    (out_tail_slot),
    .out_read_payload (out_read_payload),
    .out_read_prev    (out_read_prev),
    .out_read_next    (out_read_next)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // apply one action to the shadow list and return the reply it should produce
  function automatic list_reply_t list_apply(action_t act, logic [POS_W-1:0] pos,
                                             logic [PAY_W-1:0] data);
    list_reply_t r;
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] n;
    bit pos_live;
    r.status = ST_OK;
    r.slot = NO_SLOT;
    r.payload = '0;
    r.prv = NO_SLOT;
    r.nxt = NO_SLOT;
    pos_live = slot_used[pos];
    s = NO_SLOT;
    case (act)
      ACT_ADD_FIRST, ACT_ADD_AFTER, ACT_ADD_LAST: begin
        // lowest free slot wins
        for (int i = NSLOT - 1; i >= 0; i--)
          if (!slot_used[i]) s = IDX_W'(i);
        if (s == NO_SLOT) begin
          r.status = ST_FULL;
        end else if (act == ACT_ADD_AFTER && !pos_live) begin
          r.status = ST_FREE_POS;
        end else begin
          if (act == ACT_ADD_FIRST) p = NO_SLOT;
          else if (act == ACT_ADD_LAST) p = list_tail;
          else p = IDX_W'(pos);
          n = (p == NO_SLOT) ? list_head : link_nxt[p[POS_W-1:0]];
          slot_used[s[POS_W-1:0]] = 1'b1;
          slot_data[s[POS_W-1:0]] = data;
          link_prv[s[POS_W-1:0]] = p;
          link_nxt[s[POS_W-1:0]] = n;
          if (p != NO_SLOT) link_nxt[p[POS_W-1:0]] = s;
          else list_head = s;
          if (n != NO_SLOT) link_prv[n[POS_W-1:0]] = s;
          else list_tail = s;
          list_count = list_count + 1'b1;
          r.slot = s;
        end
      end
      ACT_DEL_FIRST, ACT_DEL_AFTER, ACT_DEL_LAST: begin
        // pick the victim, then unlink it
        if (act == ACT_DEL_AFTER) begin
          if (!pos_live) begin
            r.status = ST_FREE_POS;
          end else begin
            s = link_nxt[pos];
            if (s == NO_SLOT) r.status = ST_NO_NEXT;
          end
        end else begin
          s = (act == ACT_DEL_FIRST) ? list_head : list_tail;
          if (s == NO_SLOT) r.status = ST_EMPTY;
        end
        if (r.status == ST_OK) begin
          p = link_prv[s[POS_W-1:0]];
          n = link_nxt[s[POS_W-1:0]];
          if (p != NO_SLOT) link_nxt[p[POS_W-1:0]] = n;
          else list_head = n;
          if (n != NO_SLOT) link_prv[n[POS_W-1:0]] = p;
          else list_tail = p;
          slot_used[s[POS_W-1:0]] = 1'b0;
          if (list_count != 0) list_count = list_count - 1'b1;
          r.slot = s;
        end
      end
      ACT_CLEAR_ALL: begin
        slot_used = '{default: 1'b0};
        list_head = NO_SLOT;
        list_tail = NO_SLOT;
        list_count = '0;
      end
      default: begin
        if (!pos_live) begin
          r.status = ST_FREE_POS;
        end else begin
          r.slot = IDX_W'(pos);
          r.payload = slot_data[pos];
          r.prv = link_prv[pos];
          r.nxt = link_nxt[pos];
        end
      end
    endcase
    r.count = list_count;
    r.head = list_head;
    r.tail = list_tail;
    return r;
  endfunction

  function automatic void check_field(string name, logic [PAY_W-1:0] want,
                                      logic [PAY_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  function automatic logic [PAY_W-1:0] pick_payload();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic queue_action(action_t act, logic [POS_W-1:0] pos, logic [PAY_W-1:0] data);
    list_action_t a;
    a.act = act;
    a.pos = pos;
    a.data = data;
    pending_q.push_back(a);
  endtask

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // input driver: holds a beat until taken, idles in short bursts
  always @(negedge clk) begin : drv
    list_action_t cur;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (in_beats < total_items - CALM_ITEMS && (cyc % 384) >= 128 &&
                   $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else begin
        cur = pending_q.pop_front();
        in_valid <= 1'b1;
        in_action <= cur.act;
        in_position <= cur.pos;
        in_payload <= cur.data;
      end
    end
  end

  // result receiver: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst_n) begin
      if (ready_gap > 0) begin
        ready_gap = ready_gap - 1;
        out_ready <= 1'b0;
      end else if (!held_off && out_beats >= HOLD_AT_BEAT) begin
        held_off = 1'b1;
        ready_gap = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (in_beats < total_items - CALM_ITEMS && ((cyc + 192) % 384) >= 128 &&
                   $urandom_range(0, 5) == 0) begin
        ready_gap = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: predict on each input beat, check each result beat in order
  always @(posedge clk) begin : mon
    list_reply_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        want = list_apply(action_t'(in_action), in_position, in_payload);
        reply_q.push_back(want);
        in_beats++;
      end
      if (out_valid && out_ready) begin
        out_beats++;
        if (reply_q.size() == 0) begin
          $error("result beat with no pending expectation");
          n_fail++;
        end else begin
          want = reply_q.pop_front();
          status_seen[want.status]++;
          check_field("status", PAY_W'(want.status), PAY_W'(out_status));
          check_field("slot", PAY_W'(want.slot), PAY_W'(out_slot));
          check_field("entry_count", PAY_W'(want.count), PAY_W'(out_entry_count));
          check_field("head_slot", PAY_W'(want.head), PAY_W'(out_head_slot));
          check_field("tail_slot", PAY_W'(want.tail), PAY_W'(out_tail_slot));
          check_field("read_payload", want.payload, out_read_payload);
          check_field("read_prev", PAY_W'(want.prv), PAY_W'(out_read_prev));
          check_field("read_next", PAY_W'(want.nxt), PAY_W'(out_read_next));
        end
      end
    end
  end

  initial begin
    action_t act;
    int mode;
    int run_len;
    int r;
    int made;

    // directed: empty list errors, first adds, fill to full, full and tail cases
    queue_action(ACT_DEL_FIRST, 0, '0);
    queue_action(ACT_DEL_LAST, 0, '0);
    queue_action(ACT_DEL_AFTER, 0, '0);
    queue_action(ACT_ADD_AFTER, POS_W'(NSLOT - 1), '1);
    queue_action(ACT_READ_SLOT, POS_W'(NSLOT - 1), '0);
    queue_action(ACT_CLEAR_ALL, 0, '0);
    queue_action(ACT_ADD_FIRST, 0, '1);
    queue_action(ACT_ADD_LAST, 0, '0);
    queue_action(ACT_DEL_AFTER, 1, '0);
    queue_action(ACT_READ_SLOT, 0, '0);
    queue_action(ACT_ADD_AFTER, 0, 64'hA5A5_5A5A_F0F0_0F0F);
    for (int i = 0; i < NSLOT - 3; i++) begin
      if (i % 3 == 0) act = ACT_ADD_FIRST;
      else if (i % 3 == 1) act = ACT_ADD_AFTER;
      else act = ACT_ADD_LAST;
      queue_action(act, 0, pick_payload());
    end
    queue_action(ACT_ADD_AFTER, POS_W'(NSLOT - 1), '1);
    queue_action(ACT_ADD_FIRST, 0, '1);
    queue_action(ACT_ADD_LAST, 0, '1);
    queue_action(ACT_READ_SLOT, POS_W'(NSLOT - 1), '0);
    queue_action(ACT_DEL_AFTER, 0, '0);
    queue_action(ACT_DEL_FIRST, 0, '0);
    queue_action(ACT_DEL_LAST, 0, '0);
    queue_action(ACT_CLEAR_ALL, 0, '0);
    queue_action(ACT_READ_SLOT, 0, '0);

    // random runs: build, drain, mixed and plain noise
    made = 0;
    while (made < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 9);
      run_len = $urandom_range(16, 48);
      for (int k = 0; k < run_len; k++) begin
        r = $urandom_range(0, 99);
        if (mode <= 3) begin
          if (r < 25) act = ACT_ADD_FIRST;
          else if (r < 50) act = ACT_ADD_AFTER;
          else if (r < 70) act = ACT_ADD_LAST;
          else if (r < 82) act = ACT_READ_SLOT;
          else if (r < 88) act = ACT_DEL_FIRST;
          else if (r < 94) act = ACT_DEL_AFTER;
          else act = ACT_DEL_LAST;
        end else if (mode <= 6) begin
          if (r < 10) act = ACT_ADD_AFTER;
          else if (r < 30) act = ACT_READ_SLOT;
          else if (r < 50) act = ACT_DEL_FIRST;
          else if (r < 75) act = ACT_DEL_AFTER;
          else act = ACT_DEL_LAST;
        end else if (mode <= 8) begin
          if (r < 15) act = ACT_ADD_FIRST;
          else if (r < 30) act = ACT_ADD_AFTER;
          else if (r < 45) act = ACT_ADD_LAST;
          else if (r < 65) act = ACT_READ_SLOT;
          else if (r < 75) act = ACT_DEL_FIRST;
          else if (r < 85) act = ACT_DEL_AFTER;
          else if (r < 97) act = ACT_DEL_LAST;
          else act = ACT_CLEAR_ALL;
        end else begin
          act = action_t'($urandom_range(0, 7));
        end
        queue_action(act, POS_W'($urandom_range(0, NSLOT - 1)), pick_payload());
      end
      made += run_len;
    end
    total_items = pending_q.size();

    // synchronous reset, released on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain everything, then give the output buffer time to show strays
    while (in_beats < total_items || reply_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d list actions, %0d result beats checked, %0d mismatches",
             in_beats, out_beats, n_fail);
    $display("statuses: ok %0d, full %0d, empty %0d, free position %0d, no successor %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
